// ===== rtl/bmhq_pkg.sv =====
package bmhq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CH_W  = IDX_W + 2;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_PEEK   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [KEY_WIDTH-1:0] key_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic [6:0]         entry_count;
    } out_item_t;

    // The low KEY_WIDTH bits of the zero-extended input field form the key.
    function automatic key_t key_from_value(input logic signed [31:0] value);
        logic [63:0] wide;
        wide = 64'($unsigned(value));
        return wide[KEY_WIDTH-1:0];
    endfunction

    // The key is sign extended and then cut to the 32-bit result field.
    function automatic logic signed [31:0] key_to_value(input key_t key);
        logic [63:0] wide;
        wide = 64'(key);
        return wide[31:0];
    endfunction

    function automatic logic [6:0] count_field(input logic [CNT_W-1:0] count);
        logic [63:0] wide;
        wide = 64'(count);
        return wide[6:0];
    endfunction

endpackage

// ===== rtl/binary_max_heap_queue_unit.sv =====
// Max priority queue held as an array-based binary heap of bmhq_pkg::CAPACITY signed keys
// in one on-chip memory with one write port and two registered read ports. Every command
// transaction on the s_ side gives exactly one result transaction on the m_ side carrying
// the value, a status and the entry count after the command. The block handles one command
// at a time and is not ready while one is in progress. The block walks the tree one level
// at a time, each level being a memory read and then a compare and a move. The finishing
// step holds while the previous result still waits on the m_ side. The result register
// lets the next command be accepted while the previous result still waits.
module binary_max_heap_queue_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bmhq_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bmhq_pkg::out_item_t  m_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_WR_KEY,
        ST_DEL_RD,
        ST_DEL_GET,
        ST_DN_RD,
        ST_DN_CMP,
        ST_PEEK_RD,
        ST_PEEK_GET,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [bmhq_pkg::CNT_W-1:0]      fill_count_reg, fill_count_next;
    logic [bmhq_pkg::IDX_W-1:0]      hole_reg, hole_next;
    bmhq_pkg::key_t                  key_reg, key_next;
    logic signed [31:0]              res_value_reg, res_value_next;
    logic [1:0]                      res_status_reg, res_status_next;
    logic                            m_valid_reg, m_valid_next;
    bmhq_pkg::out_item_t             m_data_reg, m_data_next;

    // Heap storage. Entries at or above the fill count are never used.
    bmhq_pkg::key_t                  heap_mem_reg [bmhq_pkg::CAPACITY];
    bmhq_pkg::key_t                  rd_a_data_reg, rd_b_data_reg;
    logic [bmhq_pkg::IDX_W-1:0]      rd_a_addr, rd_b_addr, mem_wa;
    logic                            mem_we;
    bmhq_pkg::key_t                  mem_wd;

    // Tree navigation around the hole that the moving key will finally fill.
    logic [bmhq_pkg::IDX_W-1:0]      hole_m1, parent_idx;
    logic [bmhq_pkg::CH_W-1:0]       left_idx, right_idx, fill_ext;
    logic                            take_right;
    bmhq_pkg::key_t                  child_key;
    logic [bmhq_pkg::IDX_W-1:0]      child_idx;

    assign hole_m1    = hole_reg - bmhq_pkg::IDX_W'(1);
    assign parent_idx = hole_m1 >> 1;
    assign left_idx   = bmhq_pkg::CH_W'({hole_reg, 1'b1});
    assign right_idx  = left_idx + bmhq_pkg::CH_W'(1);
    assign fill_ext   = bmhq_pkg::CH_W'(fill_count_reg);

    // The right child wins only when it exists and is strictly larger.
    assign take_right = (right_idx < fill_ext) && (rd_a_data_reg < rd_b_data_reg);
    assign child_key  = take_right ? rd_b_data_reg : rd_a_data_reg;
    assign child_idx  = take_right ? right_idx[bmhq_pkg::IDX_W-1:0]
                                   : left_idx[bmhq_pkg::IDX_W-1:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem_reg[mem_wa] <= mem_wd;
        end
        rd_a_data_reg <= heap_mem_reg[rd_a_addr];
        rd_b_data_reg <= heap_mem_reg[rd_b_addr];
    end

    always_comb begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        hole_next       = hole_reg;
        key_next        = key_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_wa          = hole_reg;
        mem_wd          = key_reg;
        rd_a_addr       = '0;
        rd_b_addr       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_value_next  = '0;
                    res_status_next = bmhq_pkg::STATUS_OK;
                    state_next      = ST_FINISH;
                    case (s_data.command)
                        bmhq_pkg::CMD_INSERT: begin
                            if (fill_count_reg == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)) begin
                                res_status_next = bmhq_pkg::STATUS_FULL;
                            end else begin
                                hole_next       = fill_count_reg[bmhq_pkg::IDX_W-1:0];
                                key_next        = bmhq_pkg::key_from_value(s_data.value);
                                fill_count_next = fill_count_reg + bmhq_pkg::CNT_W'(1);
                                state_next = (fill_count_reg == '0) ? ST_WR_KEY : ST_UP_RD;
                            end
                        end
                        bmhq_pkg::CMD_DELETE: begin
                            if (fill_count_reg == '0) begin
                                res_status_next = bmhq_pkg::STATUS_EMPTY;
                            end else begin
                                // The hole starts one past the last entry, so that the
                                // entry below it is the one that moves to the root.
                                hole_next  = fill_count_reg[bmhq_pkg::IDX_W-1:0];
                                state_next = ST_DEL_RD;
                            end
                        end
                        bmhq_pkg::CMD_PEEK: begin
                            if (fill_count_reg == '0) begin
                                res_status_next = bmhq_pkg::STATUS_EMPTY;
                            end else begin
                                state_next = ST_PEEK_RD;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_UP_RD: begin
                rd_a_addr  = parent_idx;
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                mem_we = 1'b1;
                if (rd_a_data_reg < key_reg) begin
                    // The smaller parent drops into the hole and the hole moves up.
                    mem_wd     = rd_a_data_reg;
                    hole_next  = parent_idx;
                    state_next = (parent_idx == '0) ? ST_WR_KEY : ST_UP_RD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_WR_KEY: begin
                mem_we     = 1'b1;
                state_next = ST_FINISH;
            end
            ST_DEL_RD: begin
                rd_a_addr       = '0;
                rd_b_addr       = hole_m1;
                fill_count_next = fill_count_reg - bmhq_pkg::CNT_W'(1);
                state_next      = ST_DEL_GET;
            end
            ST_DEL_GET: begin
                res_value_next = bmhq_pkg::key_to_value(rd_a_data_reg);
                key_next       = rd_b_data_reg;
                hole_next      = '0;
                state_next     = ST_DN_RD;
            end
            ST_DN_RD: begin
                if (left_idx >= fill_ext) begin
                    mem_we     = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    rd_a_addr  = left_idx[bmhq_pkg::IDX_W-1:0];
                    rd_b_addr  = right_idx[bmhq_pkg::IDX_W-1:0];
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                mem_we = 1'b1;
                if (key_reg >= child_key) begin
                    state_next = ST_FINISH;
                end else begin
                    mem_wd     = child_key;
                    hole_next  = child_idx;
                    state_next = ST_DN_RD;
                end
            end
            ST_PEEK_RD: begin
                rd_a_addr  = '0;
                state_next = ST_PEEK_GET;
            end
            ST_PEEK_GET: begin
                res_value_next = bmhq_pkg::key_to_value(rd_a_data_reg);
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.result_value = res_value_reg;
                    m_data_next.status       = res_status_reg;
                    m_data_next.entry_count  = bmhq_pkg::count_field(fill_count_reg);
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            m_valid_reg    <= m_valid_next;
        end
        hole_reg       <= hole_next;
        key_reg        <= key_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    // The fill count never passes the capacity.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
        else $error("fill count above capacity");

    // An insert into a full queue leaves the fill count alone.
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.command == bmhq_pkg::CMD_INSERT &&
         fill_count_reg == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
        |=> $stable(fill_count_reg))
        else $error("full insert changed the fill count");

    // A delete on a non-empty queue removes exactly one entry.
    a_delete_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEL_RD)
        |=> (fill_count_reg == $past(fill_count_reg) - bmhq_pkg::CNT_W'(1)))
        else $error("delete did not remove one entry");

    // While sifting, the hole always lies inside the filled part of the heap.
    a_hole_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UP_RD || state_reg == ST_UP_CMP || state_reg == ST_DN_CMP)
        |-> (bmhq_pkg::CNT_W'(hole_reg) < fill_count_reg))
        else $error("heap hole outside the filled entries");

    // A new result is loaded only from the finishing step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside the finishing step");

endmodule

// ===== test/tb_binary_max_heap_queue_unit.sv =====
`timescale 1ns / 100ps

module tb_binary_max_heap_queue_unit;

    // Command code 3 is not decoded by the block. It must pass through as a no-op
    // that still returns one result transaction.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // After the last expected result arrives, wait this many cycles. That is enough
    // to see any stray result transaction from the slowest command.
    localparam int SETTLE_CYCLES = 20;

    // This is the long receiver hold-off that fills the block and stalls its input.
    localparam int LONG_HOLD_CYCLES = 300;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    bmhq_pkg::in_item_t   s_data;
    logic                 m_valid;
    logic                 m_ready;
    bmhq_pkg::out_item_t  m_data;

    binary_max_heap_queue_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The testbench keeps its own copy of the heap. It is updated in the order
    // in which commands are accepted. Only entries below heap_fill are ever read,
    // so unwritten entries never matter.
    bmhq_pkg::key_t heap_keys [bmhq_pkg::CAPACITY];
    int   heap_fill = 0;
    int   deepest_fill = 0;

    // Results that are predicted but not yet seen on the m_ side, oldest first.
    bmhq_pkg::out_item_t pending_replies [$];

    int err_count = 0;
    int replies_seen = 0;
    int n_insert = 0;
    int n_delete = 0;
    int n_peek = 0;
    int n_unused = 0;
    int n_full_drops = 0;
    int n_empty_reads = 0;

    // These are the idle knobs. Each side draws a wait of 0..max cycles for every
    // transaction. A max of 0 gives back-to-back traffic.
    int source_idle_max = 0;
    int sink_idle_max = 0;
    int sink_hold_cycles = 0;
    int source_gap = 0;
    bit input_held = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // This applies one command to the heap copy and returns the result that the
    // block must produce for it.
    function automatic bmhq_pkg::out_item_t heap_model_step(input logic [1:0] cmd,
                                                            input logic signed [31:0] val);
        bmhq_pkg::out_item_t reply;
        logic [63:0]         wide;
        logic signed [63:0]  ext;
        bmhq_pkg::key_t      tmp;
        int                  pos;
        int                  parent;
        int                  child;
        bit                  settled;
        reply = '0;
        case (cmd)
            bmhq_pkg::CMD_INSERT: begin
                n_insert++;
                if (heap_fill >= bmhq_pkg::CAPACITY) begin
                    reply.status = bmhq_pkg::STATUS_FULL;
                    n_full_drops++;
                end else begin
                    // The key is the low KEY_WIDTH bits of the zero-extended field.
                    wide = {32'd0, val};
                    heap_keys[heap_fill] = wide[bmhq_pkg::KEY_WIDTH-1:0];
                    pos = heap_fill;
                    heap_fill++;
                    // Sift up while the parent is strictly smaller.
                    settled = 1'b0;
                    while (pos > 0 && !settled) begin
                        parent = (pos - 1) / 2;
                        if (heap_keys[parent] < heap_keys[pos]) begin
                            tmp = heap_keys[parent];
                            heap_keys[parent] = heap_keys[pos];
                            heap_keys[pos] = tmp;
                            pos = parent;
                        end else begin
                            settled = 1'b1;
                        end
                    end
                end
            end
            bmhq_pkg::CMD_DELETE: begin
                n_delete++;
                if (heap_fill == 0) begin
                    reply.status = bmhq_pkg::STATUS_EMPTY;
                    n_empty_reads++;
                end else begin
                    ext = heap_keys[0];
                    reply.result_value = ext[31:0];
                    heap_fill--;
                    heap_keys[0] = heap_keys[heap_fill];
                    // Sift down toward the larger child. The left child wins on a tie.
                    // Stop once the parent is not smaller than that child.
                    pos = 0;
                    settled = 1'b0;
                    while (2 * pos + 1 < heap_fill && !settled) begin
                        child = 2 * pos + 1;
                        if (child + 1 < heap_fill && heap_keys[child] < heap_keys[child + 1])
                            child++;
                        if (heap_keys[pos] >= heap_keys[child]) begin
                            settled = 1'b1;
                        end else begin
                            tmp = heap_keys[pos];
                            heap_keys[pos] = heap_keys[child];
                            heap_keys[child] = tmp;
                            pos = child;
                        end
                    end
                end
            end
            bmhq_pkg::CMD_PEEK: begin
                n_peek++;
                if (heap_fill == 0) begin
                    reply.status = bmhq_pkg::STATUS_EMPTY;
                    n_empty_reads++;
                end else begin
                    ext = heap_keys[0];
                    reply.result_value = ext[31:0];
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        if (heap_fill > deepest_fill)
            deepest_fill = heap_fill;
        reply.entry_count = 7'(heap_fill);
        return reply;
    endfunction

    // This sends one command transaction. It waits out the gap that was drawn for
    // this transaction, then holds valid until the block accepts it. Valid stays
    // high after acceptance when the next gap is zero, so back-to-back transactions
    // never lower and raise valid in the same time step.
    task automatic push_command(input logic [1:0] cmd, input logic signed [31:0] val);
        bmhq_pkg::in_item_t item;
        item.command = cmd;
        item.value = val;
        repeat (source_gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_replies.push_back(heap_model_step(cmd, val));
        source_gap = $urandom_range(0, source_idle_max);
        if (source_gap > 0) begin
            s_valid <= 1'b0;
            input_held = 1'b0;
        end else begin
            input_held = 1'b1;
        end
    endtask

    // This lowers valid when it was left high for a transaction that will not come now.
    task automatic release_input();
        if (input_held) begin
            s_valid <= 1'b0;
            input_held = 1'b0;
            @(posedge aclk);
        end
    endtask

    // The sender pauses here until every predicted result has been checked.
    task automatic wait_for_drain();
        release_input();
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] draw_key();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            // A narrow range gives many equal keys, so ties are exercised on the way down.
            1, 2, 3: return 32'(int'($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // This picks a command by percentage weights. The remainder goes to the unused code.
    function automatic logic [1:0] draw_command(input int ins_pct, input int del_pct,
                                                input int peek_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            return bmhq_pkg::CMD_INSERT;
        if (roll < ins_pct + del_pct)
            return bmhq_pkg::CMD_DELETE;
        if (roll < ins_pct + del_pct + peek_pct)
            return bmhq_pkg::CMD_PEEK;
        return CMD_UNUSED;
    endfunction

    // This is the result receiver. It draws a stall before each result transaction.
    // A hold request from a test task replaces one draw with a long stretch.
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, sink_idle_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // This is the result checker. Every accepted result transaction is compared
    // field by field with the oldest prediction.
    initial begin : result_checker
        bmhq_pkg::out_item_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected result: value %0d status %0d count %0d",
                             $time, m_data.result_value, m_data.status, m_data.entry_count);
                    err_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_data.result_value !== want.result_value) begin
                        $display("%0t: result_value mismatch: expected %0d, actual %0d",
                                 $time, want.result_value, m_data.result_value);
                        err_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_data.status);
                        err_count++;
                    end
                    if (m_data.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                                 $time, want.entry_count, m_data.entry_count);
                        err_count++;
                    end
                end
            end
        end
    end

    // Delete-max and peek on an empty queue must flag empty and return zero.
    // The unused command code must be a no-op.
    task automatic test_empty_queue();
        push_command(bmhq_pkg::CMD_DELETE, 32'sh5a5a5a5a);
        push_command(bmhq_pkg::CMD_PEEK, -32'sd1);
        push_command(CMD_UNUSED, 32'sh80000000);
    endtask

    // This uses the key extremes, duplicates and every command. The deletes must
    // return the keys in descending order and finish on an empty queue.
    task automatic test_directed_extremes();
        push_command(bmhq_pkg::CMD_INSERT, 32'sd0);
        push_command(bmhq_pkg::CMD_INSERT, 32'sh7fffffff);
        push_command(bmhq_pkg::CMD_INSERT, 32'sh80000000);
        push_command(bmhq_pkg::CMD_INSERT, -32'sd1);
        push_command(bmhq_pkg::CMD_INSERT, 32'sd1);
        push_command(bmhq_pkg::CMD_INSERT, 32'sh7fffffff);
        push_command(bmhq_pkg::CMD_INSERT, 32'sd5);
        push_command(bmhq_pkg::CMD_INSERT, 32'sd5);
        push_command(bmhq_pkg::CMD_PEEK, 32'sh0);
        push_command(CMD_UNUSED, -32'sd1);
        repeat (8) push_command(bmhq_pkg::CMD_DELETE, $urandom);
        push_command(bmhq_pkg::CMD_DELETE, 32'sh0);
        push_command(bmhq_pkg::CMD_PEEK, 32'sh7fffffff);
    endtask

    // This fills the queue to capacity and pushes past it, which must drop the
    // inserts. It then empties the queue by delete-max, which reads the whole
    // content out in order.
    task automatic test_full_queue();
        while (heap_fill < bmhq_pkg::CAPACITY)
            push_command(bmhq_pkg::CMD_INSERT, draw_key());
        repeat (3) push_command(bmhq_pkg::CMD_INSERT, draw_key());
        push_command(bmhq_pkg::CMD_PEEK, $urandom);
        while (heap_fill > 0)
            push_command(bmhq_pkg::CMD_DELETE, $urandom);
        push_command(bmhq_pkg::CMD_DELETE, $urandom);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // transactions. The block runs out of room and must stall its input without
    // losing a result.
    task automatic test_output_backpressure();
        source_idle_max = 0;
        sink_hold_cycles = LONG_HOLD_CYCLES;
        repeat (30)
            push_command(draw_command(70, 20, 8), draw_key());
        wait_for_drain();
    endtask

    // The sender stops until every result is back. The next command then meets
    // an idle block.
    task automatic test_pause_until_drained();
        source_idle_max = 3;
        sink_idle_max = 3;
        repeat (12)
            push_command(draw_command(50, 35, 13), draw_key());
        wait_for_drain();
        repeat (12)
            push_command(draw_command(50, 35, 13), draw_key());
        wait_for_drain();
    endtask

    // This runs random traffic in three rounds with different idling. Each round has
    // an insert-heavy phase that runs into the full queue, a delete-heavy phase
    // that runs it dry, and a mixed phase.
    task automatic test_random_traffic();
        int src_max [3];
        int snk_max [3];
        src_max = '{0, 15, 15};
        snk_max = '{0, 15, 0};
        for (int round = 0; round < 3; round++) begin
            source_idle_max = src_max[round];
            sink_idle_max = snk_max[round];
            repeat (110) push_command(draw_command(80, 10, 8), draw_key());
            wait_for_drain();
            repeat (110) push_command(draw_command(15, 75, 8), draw_key());
            wait_for_drain();
            // The last round gives the receiver the wide stall range.
            if (round == 2) begin
                source_idle_max = 0;
                sink_idle_max = 15;
            end
            repeat (240) push_command(draw_command(45, 40, 13), draw_key());
            wait_for_drain();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        source_idle_max = 15;
        sink_idle_max = 15;
        test_empty_queue();
        test_directed_extremes();
        wait_for_drain();
        test_full_queue();
        wait_for_drain();
        test_output_backpressure();
        test_pause_until_drained();
        test_random_traffic();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Checked %0d results: %0d inserts, %0d delete-max, %0d peeks, %0d no-ops.",
                 replies_seen, n_insert, n_delete, n_peek, n_unused);
        $display("Full-queue drops %0d, empty-queue reads %0d, deepest fill %0d of %0d.",
                 n_full_drops, n_empty_reads, deepest_fill, bmhq_pkg::CAPACITY);
        if (err_count == 0) begin
            $display("binary_max_heap_queue_unit regression: pass");
        end else begin
            $display("binary_max_heap_queue_unit regression: fail");
        end
        $finish;
    end

    // This is the run limit. The slowest correct run needs well under a tenth of it.
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_replies.size());
        $display("binary_max_heap_queue_unit regression: fail");
        $finish;
    end

endmodule
